// ----- sv/psp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psp_pkg
// Shared types, codes and helpers for the parallel slave port.
// ----------------------------------------------------------------------------
package psp_pkg;

	localparam int DATA_WIDTH = 8;
	localparam int BYTE_W     = 8;

	localparam logic [1:0] ACT_PIN    = 2'd0;
	localparam logic [1:0] ACT_CPU_WR = 2'd1;
	localparam logic [1:0] ACT_CPU_RD = 2'd2;

	localparam logic [1:0] PH_INACTIVE = 2'd0;
	localparam logic [1:0] PH_READ     = 2'd1;
	localparam logic [1:0] PH_WRITE    = 2'd2;

	typedef logic [DATA_WIDTH-1:0] data_t;
	typedef logic [BYTE_W-1:0]     byte_t;

	typedef struct packed {
		logic [1:0] action;
		logic       chip_select_n;
		logic       read_strobe_n;
		logic       write_strobe_n;
		byte_t      bus_data;
		byte_t      cpu_data;
	} item_t;

	typedef struct packed {
		logic  bus_drive;
		byte_t bus_out;
		byte_t read_data;
		logic  input_full;
		logic  output_full;
		logic  input_overflow;
		logic  interrupt_pulse;
		logic  strobe_error;
	} result_t;

	// byte lane to latch width: extra latch bits are zero
	function automatic data_t data_from_byte(input byte_t b);
		data_t r;
		r = '0;
		for (int i = 0; i < DATA_WIDTH; i++) begin
			if (i < BYTE_W) begin
				r[i] = b[i];
			end
		end
		return r;
	endfunction

	// latch to byte lane: masked to eight bits
	function automatic byte_t byte_from_data(input data_t d);
		byte_t r;
		r = '0;
		for (int i = 0; i < BYTE_W; i++) begin
			if (i < DATA_WIDTH) begin
				r[i] = d[i];
			end
		end
		return r;
	endfunction

endpackage

// ----- sv/psp_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psp_core
// Port state (phase, latches, flags, mode) and the per-transfer update.
// ----------------------------------------------------------------------------
module psp_core import psp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cfg_wr_en,
	input  logic    cfg_wr_data,
	input  logic    advance,
	input  item_t   item,
	output result_t result
);

	logic       mode_q;
	logic [1:0] phase_q, phase_d;
	data_t      out_latch_q, out_latch_d;
	data_t      in_latch_q, in_latch_d;
	logic       ibf_q, ibf_d;
	logic       obf_q, obf_d;
	logic       ibov_q, ibov_d;
	logic       irq, err;
	logic       cs, rd, wr;

	assign cs = !item.chip_select_n;
	assign rd = !item.read_strobe_n;
	assign wr = !item.write_strobe_n;

	always_comb begin
		phase_d     = phase_q;
		out_latch_d = out_latch_q;
		in_latch_d  = in_latch_q;
		ibf_d       = ibf_q;
		obf_d       = obf_q;
		ibov_d      = ibov_q;
		irq         = 1'b0;
		err         = 1'b0;
		if (advance && mode_q) begin
			unique case (item.action)
				ACT_PIN: begin
					if (cs && rd && wr) begin
						err     = 1'b1;
						phase_d = PH_INACTIVE;
					end else if (cs && rd) begin
						obf_d   = 1'b0;
						phase_d = PH_READ;
					end else if (cs && wr) begin
						in_latch_d = data_from_byte(item.bus_data);
						phase_d    = PH_WRITE;
					end else begin
						// phase end, also rd+wr without select
						irq = (phase_q != PH_INACTIVE);
						if (phase_q == PH_WRITE) begin
							if (ibf_q) begin
								ibov_d = 1'b1;
							end else begin
								ibf_d = 1'b1;
							end
						end
						phase_d = PH_INACTIVE;
					end
				end
				ACT_CPU_WR: begin
					obf_d       = 1'b1;
					out_latch_d = data_from_byte(item.cpu_data);
				end
				ACT_CPU_RD: begin
					ibf_d = 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		result.bus_drive       = (phase_d == PH_READ);
		result.bus_out         = byte_from_data(out_latch_d);
		result.read_data       = byte_from_data(in_latch_d);
		result.input_full      = ibf_d;
		result.output_full     = obf_d;
		result.input_overflow  = ibov_d;
		result.interrupt_pulse = irq;
		result.strobe_error    = err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= 1'b0;
			phase_q     <= PH_INACTIVE;
			out_latch_q <= '0;
			in_latch_q  <= '0;
			ibf_q       <= 1'b0;
			obf_q       <= 1'b0;
			ibov_q      <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				mode_q <= cfg_wr_data;
			end
			phase_q     <= phase_d;
			out_latch_q <= out_latch_d;
			in_latch_q  <= in_latch_d;
			ibf_q       <= ibf_d;
			obf_q       <= obf_d;
			ibov_q      <= ibov_d;
		end
	end

	a_frozen_when_off: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !mode_q) |=> $stable({ibf_q, obf_q, ibov_q, phase_q}))
		else $error("port state changed with port mode off");

	a_ovf_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ibov_q) |-> $past(ibf_q))
		else $error("overflow set while input buffer was empty");

	a_obf_from_cpu_wr: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(obf_q) |-> $past(advance && mode_q && item.action == ACT_CPU_WR))
		else $error("output-full set without a CPU write");

	a_ibf_clr_from_cpu_rd: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(ibf_q) |-> $past(advance && mode_q && item.action == ACT_CPU_RD))
		else $error("input-full cleared without a CPU read");

endmodule

// ----- sv/parallel_slave_port.sv -----
`timescale 1ns / 1ps
// Path: input register holds a taken transfer; result register drives its result out.
// Throughput: one transfer per cycle unless out_stall holds a full result register; the
// input register refills in the same cycle it hands its item to the result register.
// Reset (arst_n low, asynchronous): port mode off, phase inactive, latches zero,
// all flags clear, both pipeline stages empty.
// ----------------------------------------------------------------------------
// parallel_slave_port
// Top level: input register, port state update, result register.
// ----------------------------------------------------------------------------
module parallel_slave_port import psp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] action,
	input  logic       chip_select_n,
	input  logic       read_strobe_n,
	input  logic       write_strobe_n,
	input  byte_t      bus_data,
	input  byte_t      cpu_data,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       bus_drive,
	output byte_t      bus_out,
	output byte_t      read_data,
	output logic       input_full,
	output logic       output_full,
	output logic       input_overflow,
	output logic       interrupt_pulse,
	output logic       strobe_error
);

	logic    valid_s1;
	item_t   item_s1;
	logic    valid_s2;
	result_t res_s2;
	result_t res;
	logic    out_free;
	logic    advance;
	logic    in_take;

	assign out_free = !valid_s2 || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.action         <= action;
			item_s1.chip_select_n  <= chip_select_n;
			item_s1.read_strobe_n  <= read_strobe_n;
			item_s1.write_strobe_n <= write_strobe_n;
			item_s1.bus_data       <= bus_data;
			item_s1.cpu_data       <= cpu_data;
		end
	end

	psp_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.advance     (advance),
		.item        (item_s1),
		.result      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid       = valid_s2;
	assign bus_drive       = res_s2.bus_drive;
	assign bus_out         = res_s2.bus_out;
	assign read_data       = res_s2.read_data;
	assign input_full      = res_s2.input_full;
	assign output_full     = res_s2.output_full;
	assign input_overflow  = res_s2.input_overflow;
	assign interrupt_pulse = res_s2.interrupt_pulse;
	assign strobe_error    = res_s2.strobe_error;

endmodule

// ----- tb/parallel_slave_port_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// parallel_slave_port_test
// Sends pin events and CPU port accesses to the parallel slave port: a
// directed table first, then random bus read and write cycles, CPU accesses
// and noise. The sender pauses between bursts and the receiver stalls.
// Every result is compared with a model of the port state kept here.
// ----------------------------------------------------------------------------
module parallel_slave_port_test;
	import psp_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef enum {STALL_NONE, STALL_LIGHT, STALL_PATTERN, STALL_HEAVY} stall_mode_t;

	typedef struct {
		logic    mode;
		item_t   it;
		logic    known;
		result_t want;
	} row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_wr_en = 1'b0;
	logic       cfg_wr_data = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [1:0] action = ACT_PIN;
	logic       chip_select_n = 1'b1;
	logic       read_strobe_n = 1'b1;
	logic       write_strobe_n = 1'b1;
	byte_t      bus_data = '0;
	byte_t      cpu_data = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       bus_drive;
	byte_t      bus_out;
	byte_t      read_data;
	logic       input_full;
	logic       output_full;
	logic       input_overflow;
	logic       interrupt_pulse;
	logic       strobe_error;

	// port state as seen from the pins and the CPU
	logic       mode_en = 1'b0;
	logic [1:0] port_phase = PH_INACTIVE;
	logic [2:0] pins_seen = 3'b000;
	byte_t      out_byte = '0;
	byte_t      in_byte = '0;
	logic       ibf = 1'b0;
	logic       obf = 1'b0;
	logic       ibov = 1'b0;

	result_t     expected_q[$];
	row_t        directed_rows[$];
	result_t     seen_res;
	result_t     want_res;
	int          fail_count = 0;
	int          idle_cycles = 0;
	int          burst_left = 0;
	int          stall_cycle = 0;
	stall_mode_t stall_kind = STALL_NONE;
	logic [31:0] stall_bits = '0;
	logic [31:0] stall_aux = '0;

	parallel_slave_port dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.action          (action),
		.chip_select_n   (chip_select_n),
		.read_strobe_n   (read_strobe_n),
		.write_strobe_n  (write_strobe_n),
		.bus_data        (bus_data),
		.cpu_data        (cpu_data),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.bus_drive       (bus_drive),
		.bus_out         (bus_out),
		.read_data       (read_data),
		.input_full      (input_full),
		.output_full     (output_full),
		.input_overflow  (input_overflow),
		.interrupt_pulse (interrupt_pulse),
		.strobe_error    (strobe_error)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// one port event: update the state, return what the port shows afterwards
	function automatic result_t advance_port(input item_t it);
		result_t r;
		logic [2:0] lv;
		logic irq;
		logic err;
		irq = 1'b0;
		err = 1'b0;
		// asserted pins: bit 0 select, bit 1 read, bit 2 write
		lv = {~it.write_strobe_n, ~it.read_strobe_n, ~it.chip_select_n};
		case (it.action)
			ACT_PIN: begin
				pins_seen = lv;
				if (mode_en) begin
					if (lv == 3'b111) begin
						err = 1'b1;
						port_phase = PH_INACTIVE;
					end else if (lv[0] && lv[1]) begin
						obf = 1'b0;
						port_phase = PH_READ;
					end else if (lv[0] && lv[2]) begin
						in_byte = it.bus_data;
						port_phase = PH_WRITE;
					end else begin
						irq = (port_phase != PH_INACTIVE);
						if (port_phase == PH_WRITE) begin
							if (ibf)
								ibov = 1'b1;
							else
								ibf = 1'b1;
						end
						port_phase = PH_INACTIVE;
					end
				end
			end
			ACT_CPU_WR: begin
				if (mode_en) begin
					obf = 1'b1;
					out_byte = it.cpu_data;
				end
			end
			ACT_CPU_RD: begin
				if (mode_en)
					ibf = 1'b0;
			end
			default: ;
		endcase
		r.bus_drive       = (port_phase == PH_READ);
		r.bus_out         = out_byte;
		r.read_data       = in_byte;
		r.input_full      = ibf;
		r.output_full     = obf;
		r.input_overflow  = ibov;
		r.interrupt_pulse = irq;
		r.strobe_error    = err;
		return r;
	endfunction

	function automatic result_t res(input logic drive, input byte_t bo, input byte_t rd,
			input logic f_in, input logic f_out, input logic f_ov, input logic irq,
			input logic err);
		return {drive, bo, rd, f_in, f_out, f_ov, irq, err};
	endfunction

	// pins_n is {chip_select_n, read_strobe_n, write_strobe_n}
	function automatic row_t row(input logic mode, input logic [1:0] act,
			input logic [2:0] pins_n, input byte_t bus, input byte_t cpu,
			input logic known, input result_t want);
		row_t r;
		r.mode = mode;
		r.it = {act, pins_n, bus, cpu};
		r.known = known;
		r.want = want;
		return r;
	endfunction

	function automatic item_t pin_item(input logic [2:0] pins_n);
		item_t it;
		it.action = ACT_PIN;
		{it.chip_select_n, it.read_strobe_n, it.write_strobe_n} = pins_n;
		it.bus_data = byte_t'($urandom);
		it.cpu_data = byte_t'($urandom);
		return it;
	endfunction

	// any level that ends a phase: select released, or select with no strobe
	function automatic logic [2:0] idle_pins();
		logic [2:0] p;
		p = 3'($urandom_range(0, 7));
		if (!p[2])
			p = 3'b011;
		return p;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endtask

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic send_transfer(input item_t it, input logic known, input result_t want);
		result_t predicted;
		if (burst_left == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
		burst_left--;
		action = it.action;
		chip_select_n = it.chip_select_n;
		read_strobe_n = it.read_strobe_n;
		write_strobe_n = it.write_strobe_n;
		bus_data = it.bus_data;
		cpu_data = it.cpu_data;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predicted = advance_port(it);
		expected_q.push_back(known ? want : predicted);
		@(negedge clk);
	endtask

	// mode register is written only with the port drained
	task automatic set_mode(input logic en);
		in_valid = 1'b0;
		while (expected_q.size() != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_wr_data = en;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		mode_en = en;
	endtask

	task automatic send_random_unit(inout int sent);
		item_t it;
		int kind;
		int reps;
		kind = $urandom_range(0, 15);
		reps = $urandom_range(1, 3);
		if (kind < 5) begin
			// bus read, select and read held over a few transfers
			repeat (reps) send_transfer(pin_item(3'b001), 1'b0, '0);
			send_transfer(pin_item(idle_pins()), 1'b0, '0);
			sent += reps + 1;
		end else if (kind < 10) begin
			// bus write, now and then straight out of a read phase
			if (kind == 9) begin
				send_transfer(pin_item(3'b001), 1'b0, '0);
				sent++;
			end
			repeat (reps) send_transfer(pin_item(3'b010), 1'b0, '0);
			send_transfer(pin_item(idle_pins()), 1'b0, '0);
			sent += reps + 1;
		end else if (kind < 14) begin
			it = pin_item(3'b111);
			it.action = (kind < 12) ? ACT_CPU_WR : ACT_CPU_RD;
			send_transfer(it, 1'b0, '0);
			sent++;
		end else if (kind == 14) begin
			send_transfer(pin_item(3'b000), 1'b0, '0);
			sent++;
		end else begin
			it = pin_item(3'($urandom_range(0, 7)));
			it.action = 2'($urandom_range(0, 3));
			send_transfer(it, 1'b0, '0);
			sent++;
		end
	endtask

	always @(negedge clk) begin
		if (stall_cycle % 97 == 0) begin
			stall_kind = stall_mode_t'($urandom_range(0, 3));
			stall_bits = $urandom;
			stall_aux = $urandom;
		end
		case (stall_kind)
			STALL_NONE:    out_stall = 1'b0;
			STALL_LIGHT:   out_stall = stall_bits[stall_cycle % 32]
				& stall_aux[(stall_cycle * 7) % 32];
			STALL_PATTERN: out_stall = stall_bits[stall_cycle % 32];
			default:       out_stall = stall_bits[stall_cycle % 32]
				| stall_aux[(stall_cycle * 7) % 32];
		endcase
		stall_cycle++;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			seen_res = {bus_drive, bus_out, read_data, input_full, output_full,
				input_overflow, interrupt_pulse, strobe_error};
			if (expected_q.size() == 0) begin
				$error("result transfer with nothing expected");
				fail_count++;
			end else begin
				want_res = expected_q.pop_front();
				check_field("bus_drive", want_res.bus_drive, seen_res.bus_drive);
				check_field("bus_out", want_res.bus_out, seen_res.bus_out);
				check_field("read_data", want_res.read_data, seen_res.read_data);
				check_field("input_full", want_res.input_full, seen_res.input_full);
				check_field("output_full", want_res.output_full, seen_res.output_full);
				check_field("input_overflow", want_res.input_overflow,
					seen_res.input_overflow);
				check_field("interrupt_pulse", want_res.interrupt_pulse,
					seen_res.interrupt_pulse);
				check_field("strobe_error", want_res.strobe_error, seen_res.strobe_error);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("parallel_slave_port test failed");
			$finish;
		end
	end

	initial begin
		int sent;
		int phase_len;
		// port off: nothing moves
		directed_rows.push_back(row(0, ACT_PIN, 3'b111, 8'h00, 8'h00, 1,
			res(0, 8'h00, 8'h00, 0, 0, 0, 0, 0)));
		directed_rows.push_back(row(0, ACT_CPU_WR, 3'b111, 8'h00, 8'hff, 1,
			res(0, 8'h00, 8'h00, 0, 0, 0, 0, 0)));
		directed_rows.push_back(row(0, ACT_PIN, 3'b010, 8'hff, 8'h00, 1,
			res(0, 8'h00, 8'h00, 0, 0, 0, 0, 0)));
		directed_rows.push_back(row(0, ACT_CPU_RD, 3'b111, 8'h00, 8'h00, 1,
			res(0, 8'h00, 8'h00, 0, 0, 0, 0, 0)));
		// port on: CPU byte out, bus read, repeated read and idle
		directed_rows.push_back(row(1, ACT_CPU_WR, 3'b111, 8'h00, 8'hff, 1,
			res(0, 8'hff, 8'h00, 0, 1, 0, 0, 0)));
		directed_rows.push_back(row(1, ACT_PIN, 3'b001, 8'h00, 8'h00, 1,
			res(1, 8'hff, 8'h00, 0, 0, 0, 0, 0)));
		directed_rows.push_back(row(1, ACT_PIN, 3'b001, 8'h00, 8'h00, 1,
			res(1, 8'hff, 8'h00, 0, 0, 0, 0, 0)));
		directed_rows.push_back(row(1, ACT_PIN, 3'b111, 8'h00, 8'h00, 1,
			res(0, 8'hff, 8'h00, 0, 0, 0, 1, 0)));
		directed_rows.push_back(row(1, ACT_PIN, 3'b111, 8'h00, 8'h00, 1,
			res(0, 8'hff, 8'h00, 0, 0, 0, 0, 0)));
		// two bus writes without a CPU read: the second overflows
		directed_rows.push_back(row(1, ACT_PIN, 3'b010, 8'hff, 8'h00, 1,
			res(0, 8'hff, 8'hff, 0, 0, 0, 0, 0)));
		directed_rows.push_back(row(1, ACT_PIN, 3'b111, 8'h00, 8'h00, 1,
			res(0, 8'hff, 8'hff, 1, 0, 0, 1, 0)));
		directed_rows.push_back(row(1, ACT_PIN, 3'b010, 8'h00, 8'hff, 1,
			res(0, 8'hff, 8'h00, 1, 0, 0, 0, 0)));
		directed_rows.push_back(row(1, ACT_PIN, 3'b111, 8'hff, 8'h00, 1,
			res(0, 8'hff, 8'h00, 1, 0, 1, 1, 0)));
		// all three asserted, then idle gives no interrupt
		directed_rows.push_back(row(1, ACT_PIN, 3'b000, 8'h5a, 8'h00, 1,
			res(0, 8'hff, 8'h00, 1, 0, 1, 0, 1)));
		directed_rows.push_back(row(1, ACT_PIN, 3'b111, 8'h00, 8'h00, 1,
			res(0, 8'hff, 8'h00, 1, 0, 1, 0, 0)));
		directed_rows.push_back(row(1, ACT_CPU_RD, 3'b111, 8'h00, 8'h00, 1,
			res(0, 8'hff, 8'h00, 0, 0, 1, 0, 0)));
		// write ended by read and write without select
		directed_rows.push_back(row(1, ACT_PIN, 3'b010, 8'ha5, 8'h3c, 0, '0));
		directed_rows.push_back(row(1, ACT_PIN, 3'b100, 8'h00, 8'h00, 0, '0));
		directed_rows.push_back(row(1, ACT_UNUSED, 3'b000, 8'hff, 8'hff, 0, '0));
		directed_rows.push_back(row(1, ACT_CPU_WR, 3'b111, 8'hff, 8'h00, 0, '0));
		// read phase straight into write phase, ended by select alone
		directed_rows.push_back(row(1, ACT_PIN, 3'b001, 8'h00, 8'h00, 0, '0));
		directed_rows.push_back(row(1, ACT_PIN, 3'b010, 8'h5a, 8'h00, 0, '0));
		directed_rows.push_back(row(1, ACT_PIN, 3'b011, 8'h00, 8'h00, 0, '0));
		directed_rows.push_back(row(1, ACT_CPU_RD, 3'b111, 8'h00, 8'h00, 0, '0));
		directed_rows.push_back(row(0, ACT_PIN, 3'b001, 8'h00, 8'h00, 0, '0));

		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].mode !== mode_en)
				set_mode(directed_rows[i].mode);
			send_transfer(directed_rows[i].it, directed_rows[i].known, directed_rows[i].want);
		end

		for (int p = 0; p < 8; p++) begin
			set_mode(p % 4 != 3);
			phase_len = mode_en ? 265 : 120;
			sent = 0;
			while (sent < phase_len)
				send_random_unit(sent);
		end

		in_valid = 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("parallel_slave_port test passed");
		else
			$display("parallel_slave_port test failed");
		$finish;
	end

endmodule
